/* rtl/core/assert_macros.svh */
// Concurrent assertion helpers, clocked on clock and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

`define ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, expr, msg)

`define ASSERT_IMPLY(lbl, ante, cons, msg)

`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* rtl/core/pie_pkg.sv */
package pie_pkg;

   localparam int XLEN      = 32;
   localparam int NUM_GPR   = 32;
   localparam int GPR_AW    = 5;
   localparam int NUM_SPR   = 16;
   localparam int SPR_AW    = 4;
   localparam int NUM_PRED  = 8;
   localparam int PRED_AW   = 3;

   // multiply result pair
   localparam logic [SPR_AW-1:0] SPR_PROD_LO = 4'd2;
   localparam logic [SPR_AW-1:0] SPR_PROD_HI = 4'd3;

   localparam logic [NUM_PRED-1:0] PRED_RESET = 8'h01;

   typedef enum logic [1:0] {
      ST_EXEC      = 2'd0,
      ST_GUARD     = 2'd1,
      ST_INVALID   = 2'd2,
      ST_UNHANDLED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      KIND_NONE = 3'd0,
      KIND_GPR  = 3'd1,
      KIND_PRED = 3'd2,
      KIND_SPR  = 3'd3,
      KIND_MUL  = 3'd4
   } kind_type;

   typedef struct packed {
      status_type       status;
      kind_type         kind;
      logic [4:0]       idx;
      logic [XLEN-1:0]  value;
      logic [XLEN-1:0]  high;
   } result_type;

   typedef enum logic [3:0] {
      FMT_NONE, FMT_ALUR, FMT_ALUI, FMT_ALUL, FMT_ALUM, FMT_ALUC,
      FMT_ALUCI, FMT_ALUP, FMT_ALUB, FMT_SPCT, FMT_SPCF
   } fmt_type;

   // major opcode [26:22], its top two bits [26:25], sub opcode [6:4]
   localparam logic [1:0] TOP_ALUI = 2'd0;
   localparam logic [1:0] TOP_NONE = 2'd2;
   localparam logic [4:0] OP_ALU   = 5'h08;
   localparam logic [4:0] OP_SPC   = 5'h09;
   localparam logic [4:0] OP_ALUL  = 5'h1F;

   localparam logic [2:0] SUB_ALUR  = 3'd0;
   localparam logic [2:0] SUB_ALUM  = 3'd2;
   localparam logic [2:0] SUB_ALUC  = 3'd3;
   localparam logic [2:0] SUB_ALUP  = 3'd4;
   localparam logic [2:0] SUB_ALUB  = 3'd5;
   localparam logic [2:0] SUB_ALUCI = 3'd6;
   localparam logic [2:0] SUB_SPCT  = 3'd2;
   localparam logic [2:0] SUB_SPCF  = 3'd3;

   localparam logic [3:0] FN_ADD    = 4'd0;
   localparam logic [3:0] FN_SUB    = 4'd1;
   localparam logic [3:0] FN_XOR    = 4'd2;
   localparam logic [3:0] FN_SL     = 4'd3;
   localparam logic [3:0] FN_SR     = 4'd4;
   localparam logic [3:0] FN_SRA    = 4'd5;
   localparam logic [3:0] FN_OR     = 4'd6;
   localparam logic [3:0] FN_AND    = 4'd7;
   localparam logic [3:0] FN_NOR    = 4'd11;
   localparam logic [3:0] FN_SHADD  = 4'd12;
   localparam logic [3:0] FN_SHADD2 = 4'd13;

   localparam logic [3:0] CMP_EQ    = 4'd0;
   localparam logic [3:0] CMP_NEQ   = 4'd1;
   localparam logic [3:0] CMP_LT    = 4'd2;
   localparam logic [3:0] CMP_LE    = 4'd3;
   localparam logic [3:0] CMP_ULT   = 4'd4;
   localparam logic [3:0] CMP_ULE   = 4'd5;
   localparam logic [3:0] CMP_BTEST = 4'd6;

   localparam logic [3:0] PFN_OR  = 4'd6;
   localparam logic [3:0] PFN_AND = 4'd7;
   localparam logic [3:0] PFN_XOR = 4'd10;

   localparam logic [3:0] MUL_SIGNED   = 4'd0;
   localparam logic [3:0] MUL_UNSIGNED = 4'd1;

endpackage

/* rtl/core/predicated_integer_execute_unit.sv */
// Integer execute stage of a predicated RISC core. One instruction word (plus the
// long immediate) is taken per cycle and each yields exactly one result beat in the
// result register: the general registers sit in a two-read-port RAM read at accept,
// and the execute cycle then runs decode, guard test, ALU, compare, predicate logic
// and a single 33x33 multiplier ahead of the result register. Sustained rate is one
// item per clock; only rsp_stall holds it back. The write of each instruction is
// forwarded to the next one, so back-to-back dependent instructions see fresh
// values. General registers read as zero until first written (per-entry valid bits,
// no clearing pass); predicates and special registers are reset flops, with p0 set.
`include "assert_macros.svh"

module predicated_integer_execute_unit (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_instruction,
   input  logic [31:0] req_long_immediate,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_dest_kind,
   output logic [4:0]  rsp_dest_index,
   output logic [31:0] rsp_dest_value,
   output logic [31:0] rsp_product_high,
   output logic [7:0]  rsp_predicate_bits
);

   logic                            req_accept;
   logic                            out_free;
   logic                            ex_fire;
   logic                            commit;

   logic                            ex_valid_ff;
   logic                            ex_valid_in;
   logic [31:0]                     ex_instr_ff;
   logic [31:0]                     ex_limm_ff;

   logic [pie_pkg::NUM_PRED-1:0]    pred_ff;
   logic [pie_pkg::NUM_PRED-1:0]    pred_in;
   logic [31:0]                     spr_ff [pie_pkg::NUM_SPR];
   logic [31:0]                     spr_in [pie_pkg::NUM_SPR];
   logic [pie_pkg::NUM_GPR-1:0]     gpr_vld_ff;
   logic [pie_pkg::NUM_GPR-1:0]     gpr_vld_in;

   logic                            byp_vld_ff;
   logic                            byp_vld_in;
   logic [pie_pkg::GPR_AW-1:0]      byp_addr_ff;
   logic [pie_pkg::GPR_AW-1:0]      byp_addr_in;
   logic [31:0]                     byp_data_ff;
   logic [31:0]                     byp_data_in;

   logic                            ram_we;
   logic [pie_pkg::GPR_AW-1:0]      ram_waddr;
   logic [31:0]                     ram_rd_a;
   logic [31:0]                     ram_rd_b;

   logic [pie_pkg::GPR_AW-1:0]      rs1;
   logic [pie_pkg::GPR_AW-1:0]      rs2;
   logic [pie_pkg::SPR_AW-1:0]      spr_sel;
   logic [31:0]                     op_a;
   logic [31:0]                     op_b;
   logic [31:0]                     spr_rd;
   pie_pkg::result_type             res;

   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   pie_pkg::result_type             rsp_res_ff;
   logic [pie_pkg::NUM_PRED-1:0]    rsp_pred_ff;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = ex_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;
   assign ex_fire    = ex_valid_ff && out_free;
   assign commit     = ex_fire && (res.status == pie_pkg::ST_EXEC);

   pie_ram #(
      .WIDTH (32),
      .DEPTH (pie_pkg::NUM_GPR)
   ) u_gpr_ram (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_waddr),
      .wr_data   (res.value),
      .rd_en     (req_accept),
      .rd_addr_a (req_instruction[16:12]),
      .rd_addr_b (req_instruction[11:7]),
      .rd_data_a (ram_rd_a),
      .rd_data_b (ram_rd_b)
   );

   assign rs1     = ex_instr_ff[16:12];
   assign rs2     = ex_instr_ff[11:7];
   assign spr_sel = ex_instr_ff[3:0];

   // forward the last register write, which this item's RAM read may have missed
   always_comb begin
      if (byp_vld_ff && byp_addr_ff == rs1) begin
         op_a = byp_data_ff;
      end else begin
         op_a = gpr_vld_ff[rs1] ? ram_rd_a : '0;
      end
      if (byp_vld_ff && byp_addr_ff == rs2) begin
         op_b = byp_data_ff;
      end else begin
         op_b = gpr_vld_ff[rs2] ? ram_rd_b : '0;
      end
   end

   assign spr_rd = (spr_sel == '0) ? {24'd0, pred_ff} : spr_ff[spr_sel];

   pie_exec u_exec (
      .instr  (ex_instr_ff),
      .limm   (ex_limm_ff),
      .op_a   (op_a),
      .op_b   (op_b),
      .spr_rd (spr_rd),
      .pred   (pred_ff),
      .res    (res)
   );

   assign ram_we    = commit && (res.kind == pie_pkg::KIND_GPR) && (res.idx != '0);
   assign ram_waddr = res.idx;

   always_comb begin
      ex_valid_in = req_stall ? ex_valid_ff : req_valid;
      pred_in     = pred_ff;
      spr_in      = spr_ff;
      gpr_vld_in  = gpr_vld_ff;
      byp_vld_in  = byp_vld_ff;
      byp_addr_in = byp_addr_ff;
      byp_data_in = byp_data_ff;

      if (ram_we) begin
         gpr_vld_in[ram_waddr] = 1'b1;
         byp_vld_in            = 1'b1;
         byp_addr_in           = ram_waddr;
         byp_data_in           = res.value;
      end

      if (commit) begin
         case (res.kind)
            pie_pkg::KIND_PRED: begin
               pred_in[res.idx[pie_pkg::PRED_AW-1:0]] = res.value[0];
               pred_in[0]                             = 1'b1;
            end
            pie_pkg::KIND_SPR: begin
               if (res.idx[pie_pkg::SPR_AW-1:0] == '0) begin
                  pred_in = res.value[pie_pkg::NUM_PRED-1:0];
               end else begin
                  spr_in[res.idx[pie_pkg::SPR_AW-1:0]] = res.value;
               end
            end
            pie_pkg::KIND_MUL: begin
               spr_in[pie_pkg::SPR_PROD_LO] = res.value;
               spr_in[pie_pkg::SPR_PROD_HI] = res.high;
            end
            default: begin
            end
         endcase
      end

      if (ex_fire) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pred_ff      <= pie_pkg::PRED_RESET;
         gpr_vld_ff   <= '0;
         byp_vld_ff   <= 1'b0;
         byp_addr_ff  <= '0;
         byp_data_ff  <= '0;
         for (int i = 0; i < pie_pkg::NUM_SPR; i++) begin
            spr_ff[i] <= '0;
         end
      end else begin
         ex_valid_ff  <= ex_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pred_ff      <= pred_in;
         gpr_vld_ff   <= gpr_vld_in;
         byp_vld_ff   <= byp_vld_in;
         byp_addr_ff  <= byp_addr_in;
         byp_data_ff  <= byp_data_in;
         spr_ff       <= spr_in;
      end
   end

   // payload: hold while stalled
   always_ff @(posedge clock) begin
      if (req_accept) begin
         ex_instr_ff <= req_instruction;
         ex_limm_ff  <= req_long_immediate;
      end
      if (ex_fire) begin
         rsp_res_ff  <= res;
         rsp_pred_ff <= pred_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_res_ff.status;
   assign rsp_dest_kind      = rsp_res_ff.kind;
   assign rsp_dest_index     = rsp_res_ff.idx;
   assign rsp_dest_value     = rsp_res_ff.value;
   assign rsp_product_high   = rsp_res_ff.high;
   assign rsp_predicate_bits = rsp_pred_ff;

   `ASSERT_ALWAYS(a_p0_set, pred_ff[0], "predicate p0 cleared")

   `ASSERT_IMPLY(a_no_r0_write, ram_we, ram_waddr != '0, "write to r0 reached the RAM")

   `ASSERT_IMPLY(a_no_write_quiet, rsp_valid_ff && rsp_res_ff.kind == pie_pkg::KIND_NONE,
      rsp_res_ff.idx == '0 && rsp_res_ff.value == '0 && rsp_res_ff.high == '0,
      "result without destination carries data")

   `ASSERT_IMPLY(a_fail_no_dest, rsp_valid_ff && rsp_res_ff.status != pie_pkg::ST_EXEC,
      rsp_res_ff.kind == pie_pkg::KIND_NONE, "non-executed beat reports a destination")

   `ASSERT_NEXT(a_bypass_tracks, ram_we,
      byp_vld_ff && byp_addr_ff == $past(ram_waddr), "bypass missed last register write")

endmodule

/* rtl/core/pie_ram.sv */
module pie_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

/* rtl/core/pie_exec.sv */
module pie_exec (
   input  logic [31:0]          instr,
   input  logic [31:0]          limm,
   input  logic [31:0]          op_a,
   input  logic [31:0]          op_b,
   input  logic [31:0]          spr_rd,
   input  logic [7:0]           pred,
   output pie_pkg::result_type  res
);

   pie_pkg::fmt_type   fmt;
   logic [1:0]         top2;
   logic [4:0]         op5;
   logic [2:0]         sub;
   logic               guard;
   logic [3:0]         func;
   logic [4:0]         rd;
   logic [2:0]         pd;
   logic [4:0]         imm5;
   logic [3:0]         low4;
   logic [31:0]        b;
   logic [4:0]         shamt;
   logic [31:0]        alu_r;
   logic               alu_ok;
   logic               cmp_r;
   logic               cmp_ok;
   logic               px;
   logic               py;
   logic               plog_r;
   logic               plog_ok;
   logic               pbit;
   logic [31:0]        bcopy;
   logic               mul_sgn;
   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [65:0] prod;

   assign top2  = instr[26:25];
   assign op5   = instr[26:22];
   assign sub   = instr[6:4];
   assign rd    = instr[21:17];
   assign pd    = instr[19:17];
   assign imm5  = instr[11:7];
   assign low4  = instr[3:0];
   assign guard = pred[instr[29:27]] ^ instr[30];

   always_comb begin
      fmt = pie_pkg::FMT_NONE;
      if (top2 == pie_pkg::TOP_ALUI) begin
         fmt = pie_pkg::FMT_ALUI;
      end else if (top2 == pie_pkg::TOP_NONE) begin
         fmt = pie_pkg::FMT_NONE;
      end else if (op5 == pie_pkg::OP_ALU) begin
         case (sub)
            pie_pkg::SUB_ALUR:  fmt = pie_pkg::FMT_ALUR;
            pie_pkg::SUB_ALUM:  fmt = pie_pkg::FMT_ALUM;
            pie_pkg::SUB_ALUC:  fmt = pie_pkg::FMT_ALUC;
            pie_pkg::SUB_ALUP:  fmt = pie_pkg::FMT_ALUP;
            pie_pkg::SUB_ALUB:  fmt = pie_pkg::FMT_ALUB;
            pie_pkg::SUB_ALUCI: fmt = pie_pkg::FMT_ALUCI;
            default:            fmt = pie_pkg::FMT_NONE;
         endcase
      end else if (op5 == pie_pkg::OP_ALUL && sub == pie_pkg::SUB_ALUR) begin
         fmt = pie_pkg::FMT_ALUL;
      end else if (op5 == pie_pkg::OP_SPC && sub == pie_pkg::SUB_SPCT) begin
         fmt = pie_pkg::FMT_SPCT;
      end else if (op5 == pie_pkg::OP_SPC && sub == pie_pkg::SUB_SPCF) begin
         fmt = pie_pkg::FMT_SPCF;
      end
   end

   assign func = (fmt == pie_pkg::FMT_ALUI) ? {1'b0, instr[24:22]} : low4;

   always_comb begin
      case (fmt)
         pie_pkg::FMT_ALUI:  b = {20'd0, instr[11:0]};
         pie_pkg::FMT_ALUL:  b = limm;
         pie_pkg::FMT_ALUCI: b = {27'd0, imm5};
         default:            b = op_b;
      endcase
   end

   assign shamt = b[4:0];

   always_comb begin
      alu_ok = 1'b1;
      case (func)
         pie_pkg::FN_ADD:    alu_r = op_a + b;
         pie_pkg::FN_SUB:    alu_r = op_a - b;
         pie_pkg::FN_XOR:    alu_r = op_a ^ b;
         pie_pkg::FN_SL:     alu_r = op_a << shamt;
         pie_pkg::FN_SR:     alu_r = op_a >> shamt;
         pie_pkg::FN_SRA:    alu_r = $unsigned($signed(op_a) >>> shamt);
         pie_pkg::FN_OR:     alu_r = op_a | b;
         pie_pkg::FN_AND:    alu_r = op_a & b;
         pie_pkg::FN_NOR:    alu_r = ~(op_a | b);
         pie_pkg::FN_SHADD:  alu_r = {op_a[30:0], 1'b0} + b;
         pie_pkg::FN_SHADD2: alu_r = {op_a[29:0], 2'b00} + b;
         default: begin
            alu_r  = '0;
            alu_ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      cmp_ok = 1'b1;
      case (func)
         pie_pkg::CMP_EQ:    cmp_r = (op_a == b);
         pie_pkg::CMP_NEQ:   cmp_r = (op_a != b);
         pie_pkg::CMP_LT:    cmp_r = ($signed(op_a) < $signed(b));
         pie_pkg::CMP_LE:    cmp_r = ($signed(op_a) <= $signed(b));
         pie_pkg::CMP_ULT:   cmp_r = (op_a < b);
         pie_pkg::CMP_ULE:   cmp_r = (op_a <= b);
         pie_pkg::CMP_BTEST: cmp_r = op_a[shamt];
         default: begin
            cmp_r  = 1'b0;
            cmp_ok = 1'b0;
         end
      endcase
   end

   // predicate operands: low bits select, top bit negates
   assign px = pred[instr[14:12]] ^ instr[15];
   assign py = pred[instr[9:7]] ^ instr[10];

   always_comb begin
      plog_ok = 1'b1;
      case (func)
         pie_pkg::PFN_OR:  plog_r = px | py;
         pie_pkg::PFN_AND: plog_r = px & py;
         pie_pkg::PFN_XOR: plog_r = px ^ py;
         default: begin
            plog_r  = 1'b0;
            plog_ok = 1'b0;
         end
      endcase
   end

   assign pbit  = pred[instr[2:0]] ^ instr[3];
   assign bcopy = (op_a & ~(32'd1 << imm5)) | ({31'd0, pbit} << imm5);

   // one 33x33 signed multiplier serves both signed and unsigned forms
   assign mul_sgn = (func == pie_pkg::MUL_SIGNED);
   assign mul_a   = $signed({mul_sgn & op_a[31], op_a});
   assign mul_b   = $signed({mul_sgn & op_b[31], op_b});
   assign prod    = mul_a * mul_b;

   always_comb begin
      res        = '0;
      res.status = pie_pkg::ST_EXEC;
      res.kind   = pie_pkg::KIND_NONE;
      if (fmt == pie_pkg::FMT_NONE) begin
         res.status = pie_pkg::ST_UNHANDLED;
      end else if (!guard) begin
         res.status = pie_pkg::ST_GUARD;
      end else begin
         case (fmt)
            pie_pkg::FMT_ALUR, pie_pkg::FMT_ALUI, pie_pkg::FMT_ALUL: begin
               if (alu_ok) begin
                  res.kind  = pie_pkg::KIND_GPR;
                  res.idx   = rd;
                  res.value = (rd != '0) ? alu_r : '0;
               end else begin
                  res.status = pie_pkg::ST_INVALID;
               end
            end
            pie_pkg::FMT_ALUM: begin
               if (func == pie_pkg::MUL_SIGNED || func == pie_pkg::MUL_UNSIGNED) begin
                  res.kind  = pie_pkg::KIND_MUL;
                  res.idx   = {1'b0, pie_pkg::SPR_PROD_LO};
                  res.value = prod[31:0];
                  res.high  = prod[63:32];
               end else begin
                  res.status = pie_pkg::ST_INVALID;
               end
            end
            pie_pkg::FMT_ALUC, pie_pkg::FMT_ALUCI: begin
               if (cmp_ok && pd != '0) begin
                  res.kind  = pie_pkg::KIND_PRED;
                  res.idx   = {2'b00, pd};
                  res.value = {31'd0, cmp_r};
               end else begin
                  res.status = pie_pkg::ST_INVALID;
               end
            end
            pie_pkg::FMT_ALUP: begin
               if (plog_ok && pd != '0) begin
                  res.kind  = pie_pkg::KIND_PRED;
                  res.idx   = {2'b00, pd};
                  res.value = {31'd0, plog_r};
               end else begin
                  res.status = pie_pkg::ST_INVALID;
               end
            end
            pie_pkg::FMT_ALUB: begin
               res.kind  = pie_pkg::KIND_GPR;
               res.idx   = rd;
               res.value = (rd != '0) ? bcopy : '0;
            end
            pie_pkg::FMT_SPCT: begin
               res.kind  = pie_pkg::KIND_SPR;
               res.idx   = {1'b0, low4};
               // s0 aliases the predicate byte; p0 stays set
               res.value = (low4 == '0) ? {24'd0, op_a[7:1], 1'b1} : op_a;
            end
            pie_pkg::FMT_SPCF: begin
               res.kind  = pie_pkg::KIND_GPR;
               res.idx   = rd;
               res.value = (rd != '0) ? spr_rd : '0;
            end
            default: begin
               res.status = pie_pkg::ST_UNHANDLED;
            end
         endcase
      end
   end

endmodule
